// ----- hdl/ipv6tp_pkg.sv -----
`default_nettype none
package ipv6tp_pkg;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_COUNT    = 2'd1,
      ST_NUMBER   = 2'd2,
      ST_DOUBLE   = 2'd3
   } status_type;

   typedef logic [15:0] word_type;

   // Beat from the character front to the address back.
   typedef struct packed {
      logic [7:0] text_char;
      logic       last;
      logic       no_char;
      logic       is_colon;
      logic       is_dot;
      logic       is_dec;
      logic       is_hex;
      logic [3:0] hex_val;
   } beat_type;

   // Parse state of the back for the string in progress.
   typedef struct packed {
      logic [7:0][15:0] head;
      logic [7:0][15:0] tail;
      logic [1:0][15:0] quad;
      logic [3:0]       hcnt;
      logic [3:0]       tcnt;
      logic             in_tail;
      logic             qseen;
      logic             colon;
      logic             seen;
      logic             odig;
      logic [15:0]      pval;
      logic [2:0]       plen;
      logic [2:0]       pflag;
      logic [2:0]       oidx;
      logic [8:0]       oval;
      status_type       err;
   } parse_type;

   // Bit positions in the part flags.
   localparam int FL_DOT     = 0;
   localparam int FL_HEXBAD  = 1;
   localparam int FL_QUADBAD = 2;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;

endpackage
`default_nettype wire

// ----- hdl/ipv6_text_parser.sv -----
`default_nettype none
// Channel   Direction  Ports
// req       in         req_text_char, req_last, req_no_char, req_valid, req_stall
// rsp       out        rsp_addr_high, rsp_addr_low, rsp_status, rsp_valid, rsp_stall
// One character is taken every cycle while req_stall is low; the last beat passes the front
// register and then the back's result register before rsp_valid rises.
// The front registers a classified beat, the back updates the part state in one step.
// Reset is synchronous and clears all control state.
// A stalled result holds and stalls the back, which then stalls the front.
module ipv6_text_parser (
   input  wire         clock,
   input  wire         reset,
   input  wire  [7:0]  req_text_char,
   input  wire         req_last,
   input  wire         req_no_char,
   input  wire         req_valid,
   output logic        req_stall,
   output logic [63:0] rsp_addr_high,
   output logic [63:0] rsp_addr_low,
   output logic [1:0]  rsp_status,
   output logic        rsp_valid,
   input  wire         rsp_stall
);
   ipv6tp_pkg::beat_type beat_data;
   logic beat_valid, beat_stall;

   ipv6tp_front u_front (
      .clock, .reset, .req_text_char, .req_last, .req_no_char, .req_valid,
      .req_stall, .beat_data, .beat_valid, .beat_stall
   );

   ipv6tp_back u_back (
      .clock, .reset, .beat_data, .beat_valid, .beat_stall,
      .rsp_addr_high, .rsp_addr_low, .rsp_status, .rsp_valid, .rsp_stall
   );
endmodule
`default_nettype wire

// ----- hdl/ipv6tp_front.sv -----
`default_nettype none
module ipv6tp_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  [7:0]              req_text_char,
   input  wire                     req_last,
   input  wire                     req_no_char,
   input  wire                     req_valid,
   output logic                    req_stall,
   output ipv6tp_pkg::beat_type    beat_data,
   output logic                    beat_valid,
   input  wire                     beat_stall
);
   ipv6tp_pkg::beat_type data_ff, data_in;
   logic valid_ff, valid_in;
   logic [7:0] c;

   assign req_stall  = valid_ff && beat_stall;
   assign beat_data  = data_ff;
   assign beat_valid = valid_ff;
   assign c = req_text_char;

   always_comb begin
      data_in = data_ff;
      valid_in = valid_ff && beat_stall;
      if (req_valid && !req_stall) begin
         valid_in = 1'b1;
         data_in.text_char = c;
         data_in.last = req_last;
         data_in.no_char = req_no_char;
         data_in.is_colon = (c == ipv6tp_pkg::CHAR_COLON);
         data_in.is_dot = (c == ipv6tp_pkg::CHAR_DOT);
         data_in.is_dec = (c inside {[8'h30:8'h39]});
         data_in.is_hex = 1'b1;
         data_in.hex_val = 4'd0;
         if (c inside {[8'h30:8'h39]}) data_in.hex_val = c[3:0];
         else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            data_in.hex_val = c[3:0] + 4'd9;
         else data_in.is_hex = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end
endmodule
`default_nettype wire

// ----- hdl/ipv6tp_back.sv -----
`default_nettype none
module ipv6tp_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire ipv6tp_pkg::beat_type beat_data,
   input  wire                     beat_valid,
   output logic                    beat_stall,
   output logic [63:0]             rsp_addr_high,
   output logic [63:0]             rsp_addr_low,
   output logic [1:0]              rsp_status,
   output logic                    rsp_valid,
   input  wire                     rsp_stall
);
   ipv6tp_pkg::parse_type ps_ff, ps_in;
   logic [63:0] hi_ff, hi_in, lo_ff, lo_in;
   ipv6tp_pkg::status_type st_ff, st_in;
   logic ov_ff, ov_in;
   logic take;
   logic [15:0] words [8];
   ipv6tp_pkg::status_type st;

   assign beat_stall = ov_ff && rsp_stall;
   assign take = beat_valid && !beat_stall;
   assign rsp_addr_high = hi_ff;
   assign rsp_addr_low = lo_ff;
   assign rsp_status = st_ff;
   assign rsp_valid = ov_ff;

   function automatic ipv6tp_pkg::parse_type clear_part(ipv6tp_pkg::parse_type s);
      s.pval = '0; s.plen = '0; s.pflag = '0;
      s.oval = '0; s.oidx = '0; s.odig = 1'b0;
      return s;
   endfunction

   function automatic ipv6tp_pkg::parse_type clear_string(ipv6tp_pkg::parse_type s);
      s = clear_part(s);
      s.hcnt = '0; s.tcnt = '0; s.in_tail = 1'b0; s.qseen = 1'b0;
      s.colon = 1'b0; s.seen = 1'b0; s.err = ipv6tp_pkg::ST_OK;
      return s;
   endfunction

   // Closes one decimal segment of a dotted quad into its byte of the quad words.
   function automatic ipv6tp_pkg::parse_type close_seg(ipv6tp_pkg::parse_type s);
      if (s.oidx < 3'd4) begin
         if (!s.odig || s.oval > 9'd255) s.pflag[ipv6tp_pkg::FL_QUADBAD] = 1'b1;
         else if (s.oidx[0]) s.quad[s.oidx[1]][7:0] = s.oval[7:0];
         else s.quad[s.oidx[1]][15:8] = s.oval[7:0];
      end
      s.oval = '0;
      s.odig = 1'b0;
      return s;
   endfunction

   function automatic ipv6tp_pkg::parse_type push_word(ipv6tp_pkg::parse_type s,
                                                       logic [15:0] w);
      if (s.in_tail) begin
         if (s.tcnt < 4'd8) s.tail[s.tcnt[2:0]] = w;
         if (s.tcnt < 4'd9) s.tcnt = s.tcnt + 4'd1;
      end else begin
         if (s.hcnt < 4'd8) s.head[s.hcnt[2:0]] = w;
         if (s.hcnt < 4'd9) s.hcnt = s.hcnt + 4'd1;
      end
      return s;
   endfunction

   // Ends the current part; only the first failing part sets the error.
   function automatic ipv6tp_pkg::parse_type finish_into(ipv6tp_pkg::parse_type s,
                                                         logic is_last);
      if (s.err == ipv6tp_pkg::ST_OK) begin
         if (s.plen == 3'd0) s.err = ipv6tp_pkg::ST_COUNT;
         else if (s.pflag[ipv6tp_pkg::FL_DOT]) begin
            if (!is_last || s.qseen) s.err = ipv6tp_pkg::ST_COUNT;
            else begin
               s.qseen = 1'b1;
               s = close_seg(s);
               if (s.pflag[ipv6tp_pkg::FL_QUADBAD] || s.oidx < 3'd3)
                  s.err = ipv6tp_pkg::ST_NUMBER;
               else if (s.oidx >= 3'd4) s.err = ipv6tp_pkg::ST_COUNT;
               else begin
                  s = push_word(s, s.quad[0]);
                  s = push_word(s, s.quad[1]);
               end
            end
         end else if (s.pflag[ipv6tp_pkg::FL_HEXBAD] || s.plen > 3'd4)
            s.err = ipv6tp_pkg::ST_NUMBER;
         else s = push_word(s, s.pval);
      end
      return s;
   endfunction

   function automatic ipv6tp_pkg::parse_type take_char(ipv6tp_pkg::parse_type s,
                                                       ipv6tp_pkg::beat_type b);
      logic [12:0] v10;
      v10 = '0;
      if (b.is_colon) begin
         if (s.colon) begin
            s.colon = 1'b0;
            if (!s.in_tail) begin
               if (s.plen != 3'd0) s = finish_into(s, 1'b1);
               s.in_tail = 1'b1;
               s = clear_part(s);
            end else s.err = ipv6tp_pkg::ST_DOUBLE;
         end else s.colon = 1'b1;
      end else begin
         if (s.colon) begin
            s = finish_into(s, 1'b0);
            s = clear_part(s);
            s.colon = 1'b0;
         end
         if (s.plen < 3'd7) s.plen = s.plen + 3'd1;
         if (b.is_hex) s.pval = {s.pval[11:0], b.hex_val};
         else s.pflag[ipv6tp_pkg::FL_HEXBAD] = 1'b1;
         if (b.is_dot) begin
            s.pflag[ipv6tp_pkg::FL_DOT] = 1'b1;
            s = close_seg(s);
            if (s.oidx < 3'd4) s.oidx = s.oidx + 3'd1;
         end else if (b.is_dec) begin
            if (s.oidx < 3'd4) begin
               v10 = {4'd0, s.oval} * 13'd10 + {9'd0, b.text_char[3:0]};
               s.oval = (v10 > 13'd256) ? 9'd256 : v10[8:0];
               s.odig = 1'b1;
            end
         end else if (s.oidx < 3'd4) s.pflag[ipv6tp_pkg::FL_QUADBAD] = 1'b1;
      end
      return s;
   endfunction

   always_comb begin
      logic [3:0] k;
      ps_in = ps_ff;
      hi_in = hi_ff; lo_in = lo_ff; st_in = st_ff;
      ov_in = ov_ff && rsp_stall;
      st = ipv6tp_pkg::ST_OK; k = 4'd0;
      for (int i = 0; i < 8; i++) words[i] = 16'd0;
      if (take) begin
         if (!beat_data.no_char) begin
            ps_in.seen = 1'b1;
            if (ps_ff.err != ipv6tp_pkg::ST_DOUBLE) ps_in = take_char(ps_in, beat_data);
         end
         if (beat_data.last) begin
            if (ps_in.err == ipv6tp_pkg::ST_DOUBLE) st = ipv6tp_pkg::ST_DOUBLE;
            else if (!ps_in.seen) st = ipv6tp_pkg::ST_COUNT;
            else begin
               if (ps_in.colon) begin
                  ps_in = finish_into(ps_in, 1'b0);
                  ps_in = clear_part(ps_in);
                  ps_in = finish_into(ps_in, 1'b1);
               end else if (ps_in.plen != 3'd0) begin
                  ps_in = finish_into(ps_in, 1'b1);
               end
               if (ps_in.err == ipv6tp_pkg::ST_OK) begin
                  if (ps_in.in_tail) begin
                     if ({1'b0, ps_in.hcnt} + {1'b0, ps_in.tcnt} > 5'd7)
                        ps_in.err = ipv6tp_pkg::ST_COUNT;
                  end else if (ps_in.hcnt != 4'd8) ps_in.err = ipv6tp_pkg::ST_COUNT;
               end
               st = ps_in.err;
            end
            if (st == ipv6tp_pkg::ST_OK) begin
               for (int i = 0; i < 8; i++) begin
                  if (!ps_in.in_tail || 4'(i) < ps_in.hcnt) words[i] = ps_in.head[i];
               end
               if (ps_in.in_tail) begin
                  for (int i = 0; i < 8; i++) begin
                     k = 4'(i) + 4'd8 - ps_in.tcnt;
                     if (4'(i) < ps_in.tcnt) words[k[2:0]] = ps_in.tail[i];
                  end
               end
            end
            hi_in = {words[0], words[1], words[2], words[3]};
            lo_in = {words[4], words[5], words[6], words[7]};
            st_in = st;
            ov_in = 1'b1;
            ps_in = clear_string(ps_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in; lo_ff <= lo_in; st_ff <= st_in;
      if (reset) begin
         ps_ff <= '0;
         ov_ff <= 1'b0;
      end else begin
         ps_ff <= ps_in;
         ov_ff <= ov_in;
      end
   end

   a_err_nonzero: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && st_ff != ipv6tp_pkg::ST_OK) |-> (hi_ff == 64'd0 && lo_ff == 64'd0))
      else $error("error result carries an address");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ps_ff.hcnt <= 4'd9 && ps_ff.tcnt <= 4'd9)
      else $error("word count overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && rsp_stall) |=> (ov_ff && $stable(st_ff)))
      else $error("stalled result changed");
endmodule
`default_nettype wire

// ----- dv/ipv6_text_parser_checker.sv -----
`timescale 1ns / 100ps
module ipv6_text_parser_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire  [7:0]  req_text_char,
   input  wire         req_last,
   input  wire         req_no_char,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [63:0] rsp_addr_high,
   input  wire  [63:0] rsp_addr_low,
   input  wire  [1:0]  rsp_status,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   output int          fail_count,
   output int          pending
);

   localparam logic [2:0] FL_DOT = 3'd1;
   localparam logic [2:0] FL_HEXBAD = 3'd2;
   localparam logic [2:0] FL_QUADBAD = 3'd4;

   typedef struct {
      logic [63:0]            high;
      logic [63:0]            low;
      ipv6tp_pkg::status_type status;
   } addr_result_type;

   addr_result_type addr_queue[$];

   ipv6tp_pkg::word_type   head_w[8];
   ipv6tp_pkg::word_type   tail_w[8];
   ipv6tp_pkg::word_type   quad_w[2];
   int                     head_n, tail_n;
   bit                     in_tail, quad_seen, colon_run, seen_any, seg_digits;
   ipv6tp_pkg::word_type   part_val;
   int                     part_len;
   logic [2:0]             part_fl;
   int                     octet_val, octet_idx;
   ipv6tp_pkg::status_type first_err;

   assign pending = addr_queue.size();

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic void clear_part();
      part_val = '0;
      part_len = 0;
      part_fl = '0;
      octet_val = 0;
      octet_idx = 0;
      seg_digits = 0;
   endfunction

   function automatic void clear_text();
      clear_part();
      head_n = 0;
      tail_n = 0;
      in_tail = 0;
      quad_seen = 0;
      colon_run = 0;
      first_err = ipv6tp_pkg::ST_OK;
      seen_any = 0;
   endfunction

   function automatic void close_seg();
      if (octet_idx < 4) begin
         if (!seg_digits || octet_val > 255) begin
            part_fl |= FL_QUADBAD;
         end else if (octet_idx[0]) begin
            quad_w[octet_idx[1]][7:0] = octet_val[7:0];
         end else begin
            quad_w[octet_idx[1]][15:8] = octet_val[7:0];
         end
      end
      octet_val = 0;
      seg_digits = 0;
   endfunction

   function automatic void push_word(ipv6tp_pkg::word_type w);
      if (in_tail) begin
         if (tail_n < 8) tail_w[tail_n] = w;
         if (tail_n < 9) tail_n++;
      end else begin
         if (head_n < 8) head_w[head_n] = w;
         if (head_n < 9) head_n++;
      end
   endfunction

   function automatic ipv6tp_pkg::status_type close_part(bit is_last);
      if (part_len == 0) return ipv6tp_pkg::ST_COUNT;
      if (part_fl & FL_DOT) begin
         if (!is_last || quad_seen) return ipv6tp_pkg::ST_COUNT;
         quad_seen = 1;
         close_seg();
         if ((part_fl & FL_QUADBAD) || octet_idx < 3) return ipv6tp_pkg::ST_NUMBER;
         if (octet_idx >= 4) return ipv6tp_pkg::ST_COUNT;
         push_word(quad_w[0]);
         push_word(quad_w[1]);
         return ipv6tp_pkg::ST_OK;
      end
      if ((part_fl & FL_HEXBAD) || part_len > 4) return ipv6tp_pkg::ST_NUMBER;
      push_word(part_val);
      return ipv6tp_pkg::ST_OK;
   endfunction

   function automatic void close_into(bit is_last);
      ipv6tp_pkg::status_type e;
      if (first_err == ipv6tp_pkg::ST_OK) begin
         e = close_part(is_last);
         if (e != ipv6tp_pkg::ST_OK) first_err = e;
      end
   endfunction

   function automatic void take_char(logic [7:0] c);
      int hv;
      if (c == ipv6tp_pkg::CHAR_COLON) begin
         if (colon_run) begin
            colon_run = 0;
            if (!in_tail) begin
               if (part_len != 0) close_into(1);
               in_tail = 1;
               clear_part();
            end else begin
               first_err = ipv6tp_pkg::ST_DOUBLE;
            end
         end else begin
            colon_run = 1;
         end
         return;
      end
      if (colon_run) begin
         close_into(0);
         clear_part();
         colon_run = 0;
      end
      if (part_len < 7) part_len++;
      if (c >= "0" && c <= "9") hv = c - "0";
      else if (c >= "a" && c <= "f") hv = c - "a" + 10;
      else if (c >= "A" && c <= "F") hv = c - "A" + 10;
      else hv = 16;
      if (hv < 16) part_val = {part_val[11:0], hv[3:0]};
      else part_fl |= FL_HEXBAD;
      if (c == ipv6tp_pkg::CHAR_DOT) begin
         part_fl |= FL_DOT;
         close_seg();
         if (octet_idx < 4) octet_idx++;
      end else if (c >= "0" && c <= "9") begin
         if (octet_idx < 4) begin
            octet_val = octet_val * 10 + (c - "0");
            if (octet_val > 256) octet_val = 256;
            seg_digits = 1;
         end
      end else if (octet_idx < 4) begin
         part_fl |= FL_QUADBAD;
      end
   endfunction

   function automatic void parse_beat(logic [7:0] c, bit last, bit no_char);
      addr_result_type r;
      ipv6tp_pkg::word_type words[8];
      if (!no_char) begin
         seen_any = 1;
         if (first_err != ipv6tp_pkg::ST_DOUBLE) take_char(c);
      end
      if (!last) return;
      r.high = '0;
      r.low = '0;
      if (first_err == ipv6tp_pkg::ST_DOUBLE) begin
         r.status = ipv6tp_pkg::ST_DOUBLE;
      end else if (!seen_any) begin
         r.status = ipv6tp_pkg::ST_COUNT;
      end else begin
         if (colon_run) begin
            close_into(0);
            clear_part();
            close_into(1);
         end else if (part_len > 0) begin
            close_into(1);
         end
         if (first_err == ipv6tp_pkg::ST_OK) begin
            if (in_tail ? (head_n + tail_n > 7) : (head_n != 8))
               first_err = ipv6tp_pkg::ST_COUNT;
         end
         r.status = first_err;
      end
      if (r.status == ipv6tp_pkg::ST_OK) begin
         foreach (words[i]) words[i] = '0;
         if (!in_tail) begin
            foreach (words[i]) words[i] = head_w[i];
         end else begin
            for (int i = 0; i < head_n && i < 8; i++) words[i] = head_w[i];
            for (int i = 0; i < tail_n && i < 8; i++) words[(8 - tail_n + i) & 7] = tail_w[i];
         end
         r.high = {words[0], words[1], words[2], words[3]};
         r.low = {words[4], words[5], words[6], words[7]};
      end
      addr_queue.insert(addr_queue.size(), r);
      clear_text();
   endfunction

   initial begin
      fail_count = 0;
      clear_text();
   end

   always @(posedge clock) begin
      addr_result_type w;
      if (reset) begin
         clear_text();
      end else begin
         if (req_valid && !req_stall) parse_beat(req_text_char, req_last, req_no_char);
         if (rsp_valid && !rsp_stall) begin
            if (addr_queue.size() == 0) begin
               report("unexpected beat", {62'd0, rsp_status}, 64'd0);
            end else begin
               w = addr_queue.pop_front();
               if (rsp_status !== w.status) report("status", rsp_status, w.status);
               if (rsp_addr_high !== w.high) report("addr_high", rsp_addr_high, w.high);
               if (rsp_addr_low !== w.low) report("addr_low", rsp_addr_low, w.low);
            end
         end
      end
   end

endmodule

// ----- dv/ipv6_text_parser_tb.sv -----
`timescale 1ns / 100ps
module ipv6_text_parser_tb;

   logic        clock = 0;
   logic        reset = 1;
   logic [7:0]  req_text_char = '0;
   logic        req_last = 0;
   logic        req_no_char = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [63:0] rsp_addr_high, rsp_addr_low;
   logic [1:0]  rsp_status;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   int          fail_count, pending;
   int          burst_left = 0;
   int          beat_count = 0;
   int          stall_mode = 0;
   int          cycle_count = 0;

   always #2 clock = ~clock;

   ipv6_text_parser uut (.*);

   ipv6_text_parser_checker checker_i (.*);

   // Receiver stall pattern: free, light random, heavy random, periodic.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((cycle_count % 5) < 2);
      endcase
   end

   task automatic send_beat(input logic [7:0] c, input bit last, input bit no_char);
      while (burst_left == 0) begin
         if ($urandom_range(0, 2) == 0) begin
            burst_left = $urandom_range(1, 30);
         end else begin
            req_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end
      end
      burst_left--;
      req_text_char <= c;
      req_last <= last;
      req_no_char <= no_char;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beat_count++;
   endtask

   task automatic send_text(input string s);
      if (s.len() == 0) begin
         send_beat(8'($urandom), 1'b1, 1'b1);
      end else begin
         for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b1);
            send_beat(s[i], i == s.len() - 1, 1'b0);
         end
      end
   endtask

   function automatic string rand_hex();
      string d = "0123456789abcdefABCDEF";
      string s = "";
      int n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      for (int i = 0; i < n; i++) s = {s, d[$urandom_range(0, 21)]};
      return s;
   endfunction

   function automatic string rand_quad();
      return $sformatf("%0d.%0d.%0d.%0d", $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(256, 999)
                                                   : $urandom_range(0, 255));
   endfunction

   function automatic string rand_side(int n, bit quad);
      string s = "";
      for (int i = 0; i < n; i++) begin
         if (i != 0) s = {s, ":"};
         s = {s, (quad && i == n - 1) ? rand_quad() : rand_hex()};
      end
      return s;
   endfunction

   function automatic string rand_addr();
      string s;
      int    k, h;
      bit    q = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
         0, 1: s = rand_side(q ? 7 : 8, q);
         2, 3: begin
            k = $urandom_range(0, 7);
            h = $urandom_range(0, k);
            s = {rand_side(h, 0), "::", rand_side(k - h, q && (k - h) > 0)};
         end
         4: s = rand_side($urandom_range(1, 9), q);
         default: begin
            s = "";
            for (int i = 0; i < $urandom_range(1, 14); i++) begin
               case ($urandom_range(0, 4))
                  0: s = {s, ":"};
                  1: s = {s, "."};
                  2: s = {s, 8'($urandom)};
                  default: s = {s, 8'($urandom_range("0", "9"))};
               endcase
            end
         end
      endcase
      // Occasional single corruption of the generated string.
      if (s.len() > 0 && $urandom_range(0, 9) == 0)
         s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
      return s;
   endfunction

   initial begin
      string directed[$];
      int    timer;
      directed = '{"", "::", "::1", "1::", "0:0:0:0:0:0:0:0",
                   "ffff:FFFF:ffff:ffff:ffff:ffff:ffff:ffff", "1:2:3:4:5:6:7:8:9",
                   "1:2:3:4:5:6:7", "1::2::3", "12345::", "g::", ":1:2:3:4:5:6:7",
                   "1:2:3:4:5:6:7:", "1:::2", "::ffff:192.168.0.1",
                   "1:2:3:4:5:6:255.255.255.255", "::1.2.3", "::1.2.3.256",
                   "::1.2.3.4.5", "::1.2.3.4:5", "1.2.3.4::1.2.3.4", "::1..2.3",
                   "1:2:3:4:5:6:7::", "::1:2:3:4:5:6:7", "a:B:c:D:e:F:0:9"};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i]) send_text(directed[i]);
      // The two extreme byte values as characters, then random strings.
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'hff, 1'b1, 1'b0);
      while (beat_count < 650) send_text(rand_addr());
      req_valid <= 0;
      timer = 0;
      while (pending != 0 && timer < 10000) begin
         @(posedge clock);
         timer++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/ipv6tp_pkg.sv
hdl/ipv6tp_front.sv
hdl/ipv6tp_back.sv
hdl/ipv6_text_parser.sv
dv/ipv6_text_parser_checker.sv
dv/ipv6_text_parser_tb.sv
